// ===== src/lgs_pkg.sv =====
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int unsigned COORD_W = 9;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned AIM_W   = 8;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned CFG_IDX_W = 3;

  // raw aim (8b) times span magnitude (9b)
  localparam int unsigned PROD_W = AIM_W + COORD_W;

  // 299*r + 587*g + 114*b tops out at 255000
  localparam int unsigned LUMA_W = 18;
  localparam logic [9:0] LUMA_CR = 10'd299;
  localparam logic [9:0] LUMA_CG = 10'd587;
  localparam logic [9:0] LUMA_CB = 10'd114;
  localparam logic [9:0] LUMA_DIV = 10'd1000;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIS_MIN_X = 3'd0,
    CFG_VIS_MAX_X = 3'd1,
    CFG_VIS_MIN_Y = 3'd2,
    CFG_VIS_MAX_Y = 3'd3,
    CFG_THRESHOLD = 3'd4
  } lgs_cfg_e;

  // per-pixel area test result
  typedef struct packed {
    logic in_area;  // pixel lies in the clipped aim area
    logic on_grid;  // offset from chord start is a sample point
  } lgs_hit_t;

endpackage

// ===== src/light_gun_sensor.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents (lowest bit first)
// s_axis    in   64     pixel_x[8:0] pixel_y[17:9] red[25:18] green[33:26] blue[41:34]
//                       aim_x[49:42] aim_y[57:50], upper bits zero
// m_axis    out  8      sensor_line[0] line_changed[1], upper bits zero
// cfg       in   9      cfg_we_i / cfg_idx_i / cfg_data_i, single-cycle register write
//
// One pixel per cycle sustained while m_axis accepts; each result passes the input reg,
// multiply, divide fixup, area test and sensor/output reg stages in that order.
// The only feedback is the 1-bit sensor level, resolved in the output stage.
// Each stage advances whenever its successor is empty or advancing, so bubbles fill
// behind a stalled output; s_axis_tready drops only when all stages hold data and
// m_axis is stalled. Async reset empties the pipeline, restores defaults, sensor 1 (off).

module light_gun_sensor #(
  parameter int unsigned AIM_RADIUS  = 6,
  parameter int unsigned SAMPLE_STEP = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel_x, pixel_y, red, green, blue, aim_x, aim_y
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lgs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // sensor_line, line_changed
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lgs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lgs_pkg::CFG_W-1:0]           cfg_data_i
);
  import lgs_pkg::*;

  // ---------------- configuration registers ----------------
  logic [COORD_W-1:0] vis_min_x_q, vis_max_x_q, vis_min_y_q, vis_max_y_q;
  // threshold kept pre-scaled by 1000 so luma needs no divider
  logic [LUMA_W-1:0]  thr_x1000_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_min_x_q <= COORD_W'(0);
      vis_max_x_q <= COORD_W'(255);
      vis_min_y_q <= COORD_W'(0);
      vis_max_y_q <= COORD_W'(191);
      thr_x1000_q <= LUMA_W'(127000);
    end else if (cfg_we_i) begin
      case (lgs_cfg_e'(cfg_idx_i))
        CFG_VIS_MIN_X: vis_min_x_q <= cfg_data_i;
        CFG_VIS_MAX_X: vis_max_x_q <= cfg_data_i;
        CFG_VIS_MIN_Y: vis_min_y_q <= cfg_data_i;
        CFG_VIS_MAX_Y: vis_max_y_q <= cfg_data_i;
        CFG_THRESHOLD: thr_x1000_q <= LUMA_W'(cfg_data_i[THR_W-1:0]) * LUMA_W'(LUMA_DIV);
        default: ;
      endcase
    end
  end

  // ---------------- stage valids and flow control ----------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_v_q || m_axis_tready;
  assign rdy4 = !s4_v_q || rdy5;
  assign rdy3 = !s3_v_q || rdy4;
  assign rdy2 = !s2_v_q || rdy3;
  assign rdy1 = !s1_v_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q  <= s_axis_tvalid;
      if (rdy2) s2_v_q  <= s1_v_q;
      if (rdy3) s3_v_q  <= s2_v_q;
      if (rdy4) s4_v_q  <= s3_v_q;
      if (rdy5) out_v_q <= s4_v_q;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [COORD_W-1:0] s1_px_q, s1_py_q;
  logic [COLOR_W-1:0] s1_r_q, s1_g_q, s1_b_q;
  logic [AIM_W-1:0]   s1_ax_q, s1_ay_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_px_q <= s_axis_tdata[8:0];
      s1_py_q <= s_axis_tdata[17:9];
      s1_r_q  <= s_axis_tdata[25:18];
      s1_g_q  <= s_axis_tdata[33:26];
      s1_b_q  <= s_axis_tdata[41:34];
      s1_ax_q <= s_axis_tdata[49:42];
      s1_ay_q <= s_axis_tdata[57:50];
    end
  end

  // ---------------- stage 2: aim products, weighted luma sum ----------------
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic               neg_x, neg_y;
  logic [LUMA_W-1:0]  luma_sum;

  lgs_scale_mul u_mul_x (
    .raw_i (s1_ax_q),
    .lo_i  (vis_min_x_q),
    .hi_i  (vis_max_x_q),
    .prod_o(prod_x),
    .neg_o (neg_x)
  );

  lgs_scale_mul u_mul_y (
    .raw_i (s1_ay_q),
    .lo_i  (vis_min_y_q),
    .hi_i  (vis_max_y_q),
    .prod_o(prod_y),
    .neg_o (neg_y)
  );

  // constant coefficients, so these reduce to shift-add trees
  assign luma_sum = LUMA_W'(s1_r_q) * LUMA_W'(LUMA_CR)
                  + LUMA_W'(s1_g_q) * LUMA_W'(LUMA_CG)
                  + LUMA_W'(s1_b_q) * LUMA_W'(LUMA_CB);

  logic [COORD_W-1:0] s2_px_q, s2_py_q;
  logic [PROD_W-1:0]  s2_prod_x_q, s2_prod_y_q;
  logic               s2_neg_x_q, s2_neg_y_q;
  logic [LUMA_W-1:0]  s2_luma_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_px_q     <= s1_px_q;
      s2_py_q     <= s1_py_q;
      s2_prod_x_q <= prod_x;
      s2_prod_y_q <= prod_y;
      s2_neg_x_q  <= neg_x;
      s2_neg_y_q  <= neg_y;
      s2_luma_q   <= luma_sum;
    end
  end

  // ---------------- stage 3: divide by 255, brightness compare ----------------
  logic [COORD_W-1:0] gx, gy;

  lgs_scale_fix u_fix_x (
    .prod_i(s2_prod_x_q),
    .neg_i (s2_neg_x_q),
    .lo_i  (vis_min_x_q),
    .pos_o (gx)
  );

  lgs_scale_fix u_fix_y (
    .prod_i(s2_prod_y_q),
    .neg_i (s2_neg_y_q),
    .lo_i  (vis_min_y_q),
    .pos_o (gy)
  );

  logic [COORD_W-1:0] s3_px_q, s3_py_q, s3_gx_q, s3_gy_q;
  logic               s3_bright_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_px_q     <= s2_px_q;
      s3_py_q     <= s2_py_q;
      s3_gx_q     <= gx;
      s3_gy_q     <= gy;
      // floor(sum/1000) >= thr  <=>  sum >= thr*1000
      s3_bright_q <= (s2_luma_q >= thr_x1000_q);
    end
  end

  // ---------------- stage 4: clipped aim area test ----------------
  lgs_hit_t hit;

  lgs_hit_test #(
    .AIM_RADIUS (AIM_RADIUS),
    .SAMPLE_STEP(SAMPLE_STEP)
  ) u_hit (
    .px_i       (s3_px_q),
    .py_i       (s3_py_q),
    .gx_i       (s3_gx_q),
    .gy_i       (s3_gy_q),
    .vis_min_x_i(vis_min_x_q),
    .vis_max_x_i(vis_max_x_q),
    .vis_min_y_i(vis_min_y_q),
    .vis_max_y_i(vis_max_y_q),
    .hit_o      (hit)
  );

  lgs_hit_t s4_hit_q;
  logic     s4_bright_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_hit_q    <= hit;
      s4_bright_q <= s3_bright_q;
    end
  end

  // ---------------- stage 5: sensor level and output register ----------------
  // Outside the area: off. Already on: stays on. Off: a bright sample turns it on.
  logic sensor_q, sensor_d, changed_q;

  always_comb begin
    sensor_d = 1'b1;
    if (s4_hit_q.in_area) begin
      if (!sensor_q) begin
        sensor_d = 1'b0;
      end else if (s4_hit_q.on_grid && s4_bright_q) begin
        sensor_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_q  <= 1'b1;
      changed_q <= 1'b0;
    end else if (rdy5 && s4_v_q) begin
      sensor_q  <= sensor_d;
      changed_q <= (sensor_d != sensor_q);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-2)'(0), changed_q, sensor_q};

endmodule

// ===== src/lgs_scale_mul.sv =====
`timescale 1ns / 1ps

module lgs_scale_mul (
  input  logic [lgs_pkg::AIM_W-1:0]   raw_i,
  input  logic [lgs_pkg::COORD_W-1:0] lo_i,
  input  logic [lgs_pkg::COORD_W-1:0] hi_i,
  output logic [lgs_pkg::PROD_W-1:0]  prod_o,
  output logic                        neg_o
);
  import lgs_pkg::*;

  logic [COORD_W-1:0] mag;

  assign neg_o  = (hi_i < lo_i);
  assign mag    = neg_o ? (lo_i - hi_i) : (hi_i - lo_i);
  assign prod_o = PROD_W'(raw_i) * PROD_W'(mag);

endmodule

// ===== src/lgs_scale_fix.sv =====
`timescale 1ns / 1ps

module lgs_scale_fix (
  input  logic [lgs_pkg::PROD_W-1:0]  prod_i,
  input  logic                        neg_i,
  input  logic [lgs_pkg::COORD_W-1:0] lo_i,
  output logic [lgs_pkg::COORD_W-1:0] pos_o
);
  import lgs_pkg::*;

  // prod/255: estimate (p + p/256)/256 is never high and at most one low
  logic [PROD_W:0]    est_sum;
  logic [COORD_W:0]   q_est;
  logic [PROD_W:0]    q_x255;
  logic [PROD_W:0]    rem;
  logic [COORD_W-1:0] off;

  assign est_sum = (PROD_W+1)'(prod_i) + (PROD_W+1)'(prod_i >> 8);
  assign q_est   = est_sum[PROD_W:8];
  assign q_x255  = ((PROD_W+1)'(q_est) << 8) - (PROD_W+1)'(q_est);
  assign rem     = (PROD_W+1)'(prod_i) - q_x255;
  assign off     = COORD_W'(q_est) + COORD_W'(rem >= (PROD_W+1)'(255));
  assign pos_o   = neg_i ? (lo_i - off) : (lo_i + off);

endmodule

// ===== src/lgs_hit_test.sv =====
`timescale 1ns / 1ps

module lgs_hit_test #(
  parameter int unsigned AIM_RADIUS  = 6,
  parameter int unsigned SAMPLE_STEP = 4
) (
  input  logic [lgs_pkg::COORD_W-1:0] px_i,
  input  logic [lgs_pkg::COORD_W-1:0] py_i,
  input  logic [lgs_pkg::COORD_W-1:0] gx_i,
  input  logic [lgs_pkg::COORD_W-1:0] gy_i,
  input  logic [lgs_pkg::COORD_W-1:0] vis_min_x_i,
  input  logic [lgs_pkg::COORD_W-1:0] vis_max_x_i,
  input  logic [lgs_pkg::COORD_W-1:0] vis_min_y_i,
  input  logic [lgs_pkg::COORD_W-1:0] vis_max_y_i,
  output lgs_pkg::lgs_hit_t           hit_o
);
  import lgs_pkg::*;

  localparam int unsigned RW = $clog2(AIM_RADIUS + 1);
  localparam int unsigned DW = $clog2(2 * AIM_RADIUS + 1);
  localparam int unsigned NK = (2 * AIM_RADIUS) / SAMPLE_STEP;
  localparam int unsigned SW = COORD_W + 2;
  localparam logic signed [SW-1:0] RAD = SW'(AIM_RADIUS);

  function automatic logic [RW-1:0] ceil_sqrt(input int v);
    int k;
    k = 0;
    for (int i = 0; i <= AIM_RADIUS; i++) begin
      if (k * k < v) begin
        k = k + 1;
      end
    end
    return RW'(k);
  endfunction

  logic [RW-1:0]         chord_tbl [AIM_RADIUS+1];
  logic signed [SW-1:0]  px, py, gx, gy;
  logic signed [SW-1:0]  vminx, vmaxx, vminy, vmaxy;
  logic signed [SW-1:0]  ylo, yhi, ymin, ymax, dy_s, dy_abs;
  logic signed [SW-1:0]  dx, xlo, xhi, xmin, xmax, diff;
  logic                  in_y;
  logic [RW-1:0]         dy_idx;
  logic [DW-1:0]         diff_n;
  logic                  grid;

  always_comb begin
    for (int d = 0; d <= AIM_RADIUS; d++) begin
      chord_tbl[d] = ceil_sqrt(AIM_RADIUS * AIM_RADIUS - d * d);
    end
  end

  assign px    = signed'(SW'(px_i));
  assign py    = signed'(SW'(py_i));
  assign gx    = signed'(SW'(gx_i));
  assign gy    = signed'(SW'(gy_i));
  assign vminx = signed'(SW'(vis_min_x_i));
  assign vmaxx = signed'(SW'(vis_max_x_i));
  assign vminy = signed'(SW'(vis_min_y_i));
  assign vmaxy = signed'(SW'(vis_max_y_i));

  // vertical extent, clipped to the visible lines
  assign ylo  = gy - RAD;
  assign yhi  = gy + RAD;
  assign ymin = (ylo < vminy) ? vminy : ylo;
  assign ymax = (yhi > vmaxy) ? vmaxy : yhi;
  assign in_y = (py >= ymin) && (py <= ymax);

  // inside the extent |dy| <= radius, so the low bits index the chord table
  assign dy_s   = py - gy;
  assign dy_abs = dy_s[SW-1] ? -dy_s : dy_s;
  assign dy_idx = in_y ? dy_abs[RW-1:0] : '0;
  assign dx     = signed'(SW'(chord_tbl[dy_idx]));

  assign xlo  = gx - dx;
  assign xhi  = gx + dx;
  assign xmin = (xlo < vminx) ? vminx : xlo;
  assign xmax = (xhi > vmaxx) ? vmaxx : xhi;
  assign diff = px - xmin;
  assign diff_n = diff[DW-1:0];

  always_comb begin
    grid = 1'b0;
    for (int k = 0; k <= NK; k++) begin
      if (diff_n == DW'(k * SAMPLE_STEP)) begin
        grid = 1'b1;
      end
    end
  end

  assign hit_o.in_area = in_y && (px >= xmin) && (px <= xmax);
  assign hit_o.on_grid = grid;

endmodule

// ===== src/lgs_checker.sv =====
`timescale 1ns / 1ps

module lgs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lgs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import lgs_pkg::*;

  // level of the last delivered result; sensor starts off
  logic last_line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_line_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_line_q <= m_axis_tdata[0];
    end
  end

  // change flag must match the level step between consecutive results
  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |->
      (m_axis_tdata[1] == (m_axis_tdata[0] != last_line_q)))
    else $error("line_changed inconsistent with sensor_line history");

  // input can only be back-pressured by a stalled, full output
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled while output empty");

  // pipeline is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("result valid straight out of reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind light_gun_sensor lgs_checker u_lgs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
